// ===== rtl/bcim_pkg.sv =====
// Shared types, constants and register codes of the bilinear corner index mapper.
package bcim_pkg;

   localparam int MAX_GRID_WIDTH_DEFAULT  = 64;
   localparam int MAX_GRID_HEIGHT_DEFAULT = 64;
   localparam int FRAC_BITS_DEFAULT       = 16;

   localparam int POS_W         = 32;
   localparam int SCALE_W       = 32;
   localparam int SIZE_W        = 7;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CORNER_W      = 2;
   localparam int CELL_W        = 6;
   localparam int SLOT_W        = 12;
   localparam int ENTRY_W       = 13;
   localparam int WEIGHT_W      = 17;
   localparam int MIN_GRID_SIZE = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 3'd5;

   localparam logic signed [POS_W-1:0] ORIGIN_RESET    = '0;
   localparam logic [SCALE_W-1:0]      SCALE_RESET     = 32'h0100_0000;
   localparam logic [SIZE_W-1:0]       GRID_SIZE_RESET = 7'd64;

   localparam logic [CORNER_W-1:0] CORNER_X1Y1 = 2'd0;
   localparam logic [CORNER_W-1:0] CORNER_X2Y2 = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GEOM,
      ST_CORNER
   } state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] origin_x;
      logic signed [POS_W-1:0] origin_y;
      logic [SCALE_W-1:0]      scale_x;
      logic [SCALE_W-1:0]      scale_y;
      logic [SIZE_W-1:0]       grid_width;
      logic [SIZE_W-1:0]       grid_height;
   } cfg_type;

   typedef struct packed {
      logic                vld;
      logic [CORNER_W-1:0] corner;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } corner_req_type;

   typedef struct packed {
      logic                vld;
      logic [CORNER_W-1:0] corner;
      logic [CELL_W-1:0]   cell_x;
      logic [CELL_W-1:0]   cell_y;
      logic [SLOT_W-1:0]   slot;
      logic [WEIGHT_W-1:0] weight;
      logic                is_new;
      logic                last;
   } corner_rsp_type;

endpackage

// ===== rtl/bilinear_corner_index_mapper_unit.sv =====
// Top level of the bilinear corner index mapper: registers, sequencer, corner issue.
//
// Usage:
//   A position word (req_pos_x, req_pos_y) is taken at a rising edge with start high
//   and busy low. The block then emits four corner results, x1y1, x2y1, x1y2, x2y2,
//   on consecutive cycles, each marked by rsp_valid for one cycle; the fourth has
//   rsp_last set. The receiver cannot stall the result channel.
//   Sequence: a position passes the offset, scale multiply, clip and corner split
//   stages, then four map read-modify-writes, one per corner through the single read
//   port of the cell map; the sequencer then returns to idle, and only then is a new
//   position accepted.
//   Configuration: csr_valid/csr_ready with csr_index and csr_wdata; csr_ready is always
//   high. Write registers only while busy is low and no results are pending.
//   Reset: synchronous, active high. After reset the cell map is cleared by a sweep over
//   all MAX_GRID_WIDTH*MAX_GRID_HEIGHT entries (4096 by default) with busy held high;
//   register writes are taken during the sweep.
module bilinear_corner_index_mapper_unit #(
   parameter int MAX_GRID_WIDTH  = bcim_pkg::MAX_GRID_WIDTH_DEFAULT,
   parameter int MAX_GRID_HEIGHT = bcim_pkg::MAX_GRID_HEIGHT_DEFAULT,
   parameter int FRAC_BITS       = bcim_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [bcim_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [bcim_pkg::POS_W-1:0]     req_pos_y,
   output logic                                  rsp_valid,
   output logic [bcim_pkg::CORNER_W-1:0]         rsp_corner,
   output logic [bcim_pkg::CELL_W-1:0]           rsp_cell_x,
   output logic [bcim_pkg::CELL_W-1:0]           rsp_cell_y,
   output logic [bcim_pkg::SLOT_W-1:0]           rsp_slot,
   output logic [bcim_pkg::WEIGHT_W-1:0]         rsp_weight,
   output logic                                  rsp_is_new,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bcim_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bcim_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int XW     = $clog2(MAX_GRID_WIDTH);
   localparam int YW     = $clog2(MAX_GRID_HEIGHT);
   localparam int ADDR_W = $clog2(MAX_GRID_WIDTH * MAX_GRID_HEIGHT);
   localparam int F1     = FRAC_BITS + 1;
   localparam int WP_W   = 2 * FRAC_BITS + 2;
   localparam int WSH    = 2 * FRAC_BITS - 16;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // configuration registers
   bcim_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcim_pkg::CSR_ORIGIN_X:    cfg_in.origin_x    = csr_wdata;
            bcim_pkg::CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_wdata;
            bcim_pkg::CSR_SCALE_X:     cfg_in.scale_x     = csr_wdata;
            bcim_pkg::CSR_SCALE_Y:     cfg_in.scale_y     = csr_wdata;
            bcim_pkg::CSR_GRID_WIDTH:  cfg_in.grid_width  = csr_wdata[bcim_pkg::SIZE_W-1:0];
            bcim_pkg::CSR_GRID_HEIGHT: cfg_in.grid_height = csr_wdata[bcim_pkg::SIZE_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // sequencer
   bcim_pkg::state_type           state_ff, state_in;
   logic [bcim_pkg::CORNER_W-1:0] corner_ff, corner_in;
   logic                          accept;
   logic                          geom_done;
   logic                          clearing;

   assign accept = start && (state_ff == bcim_pkg::ST_IDLE);
   assign busy   = (state_ff != bcim_pkg::ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         bcim_pkg::ST_CLEAR: begin
            if (!clearing) begin
               state_in = bcim_pkg::ST_IDLE;
            end
         end
         bcim_pkg::ST_IDLE: begin
            if (start) begin
               state_in = bcim_pkg::ST_GEOM;
            end
         end
         bcim_pkg::ST_GEOM: begin
            if (geom_done) begin
               state_in  = bcim_pkg::ST_CORNER;
               corner_in = bcim_pkg::CORNER_X1Y1;
            end
         end
         bcim_pkg::ST_CORNER: begin
            corner_in = corner_ff + bcim_pkg::CORNER_W'(1);
            if (corner_ff == bcim_pkg::CORNER_X2Y2) begin
               state_in = bcim_pkg::ST_IDLE;
            end
         end
         default: state_in = bcim_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bcim_pkg::ST_CLEAR;
         corner_ff <= bcim_pkg::CORNER_X1Y1;
         cfg_ff.origin_x    <= bcim_pkg::ORIGIN_RESET;
         cfg_ff.origin_y    <= bcim_pkg::ORIGIN_RESET;
         cfg_ff.scale_x     <= bcim_pkg::SCALE_RESET;
         cfg_ff.scale_y     <= bcim_pkg::SCALE_RESET;
         cfg_ff.grid_width  <= bcim_pkg::GRID_SIZE_RESET;
         cfg_ff.grid_height <= bcim_pkg::GRID_SIZE_RESET;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
         cfg_ff    <= cfg_in;
      end
   end

   // coordinate pipeline
   logic [XW-1:0]        x1, x2;
   logic [YW-1:0]        y1, y2;
   logic [ADDR_W-1:0]    base1, base2;
   logic [FRAC_BITS-1:0] frac_x, frac_y;

   bcim_geom #(
      .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
      .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT),
      .FRAC_BITS       (FRAC_BITS)
   ) u_geom (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .pos_x  (req_pos_x),
      .pos_y  (req_pos_y),
      .cfg    (cfg_ff),
      .done   (geom_done),
      .x1     (x1),
      .x2     (x2),
      .y1     (y1),
      .y2     (y2),
      .base1  (base1),
      .base2  (base2),
      .frac_x (frac_x),
      .frac_y (frac_y)
   );

   // corner issue: bit 0 picks x2, bit 1 picks y2
   bcim_pkg::corner_req_type creq;
   logic [ADDR_W-1:0]        caddr;
   logic [XW-1:0]            x_sel;
   logic [YW-1:0]            y_sel;
   logic [F1-1:0]            wa, wb;
   logic [WP_W-1:0]          wprod;

   always_comb begin
      x_sel = corner_ff[0] ? x2 : x1;
      y_sel = corner_ff[1] ? y2 : y1;
      caddr = ADDR_W'(x_sel) + (corner_ff[1] ? base2 : base1);
      wa    = corner_ff[0] ? F1'(frac_x) : ONE - F1'(frac_x);
      wb    = corner_ff[1] ? F1'(frac_y) : ONE - F1'(frac_y);
      wprod = WP_W'(wa) * WP_W'(wb);

      creq.vld    = (state_ff == bcim_pkg::ST_CORNER);
      creq.corner = corner_ff;
      creq.cell_x = bcim_pkg::CELL_W'(x_sel);
      creq.cell_y = bcim_pkg::CELL_W'(y_sel);
      creq.weight = wprod[WSH +: bcim_pkg::WEIGHT_W];
      creq.last   = (corner_ff == bcim_pkg::CORNER_X2Y2);
   end

   bcim_pkg::corner_rsp_type crsp;

   bcim_slot #(
      .MAX_GRID_WIDTH  (MAX_GRID_WIDTH),
      .MAX_GRID_HEIGHT (MAX_GRID_HEIGHT)
   ) u_slot (
      .clock    (clock),
      .reset    (reset),
      .req      (creq),
      .req_addr (caddr),
      .rsp      (crsp),
      .clearing (clearing)
   );

   assign rsp_valid  = crsp.vld;
   assign rsp_corner = crsp.corner;
   assign rsp_cell_x = crsp.cell_x;
   assign rsp_cell_y = crsp.cell_y;
   assign rsp_slot   = crsp.slot;
   assign rsp_weight = crsp.weight;
   assign rsp_is_new = crsp.is_new;
   assign rsp_last   = crsp.last;

endmodule

// ===== rtl/bcim_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
module bcim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bcim_geom.sv =====
// Grid coordinate pipeline: offset, scale multiply, edge clip and corner split.
module bcim_geom #(
   parameter int MAX_GRID_WIDTH  = bcim_pkg::MAX_GRID_WIDTH_DEFAULT,
   parameter int MAX_GRID_HEIGHT = bcim_pkg::MAX_GRID_HEIGHT_DEFAULT,
   parameter int FRAC_BITS       = bcim_pkg::FRAC_BITS_DEFAULT,
   localparam int XW     = $clog2(MAX_GRID_WIDTH),
   localparam int YW     = $clog2(MAX_GRID_HEIGHT),
   localparam int ADDR_W = $clog2(MAX_GRID_WIDTH * MAX_GRID_HEIGHT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [bcim_pkg::POS_W-1:0]   pos_x,
   input  logic signed [bcim_pkg::POS_W-1:0]   pos_y,
   input  bcim_pkg::cfg_type                   cfg,
   output logic                                done,
   output logic [XW-1:0]                       x1,
   output logic [XW-1:0]                       x2,
   output logic [YW-1:0]                       y1,
   output logic [YW-1:0]                       y2,
   output logic [ADDR_W-1:0]                   base1,
   output logic [ADDR_W-1:0]                   base2,
   output logic [FRAC_BITS-1:0]                frac_x,
   output logic [FRAC_BITS-1:0]                frac_y
);

   localparam int GWW   = $clog2(MAX_GRID_WIDTH + 1);
   localparam int GHW   = $clog2(MAX_GRID_HEIGHT + 1);
   localparam int D_W   = bcim_pkg::POS_W + 1;
   localparam int P_W   = bcim_pkg::POS_W + bcim_pkg::SCALE_W;
   localparam int SHIFT = 32 - FRAC_BITS;
   localparam int G_W   = P_W - SHIFT;
   localparam int CX_W  = XW + FRAC_BITS;
   localparam int CY_W  = YW + FRAC_BITS;
   localparam int BX_W  = YW + GWW;

   // effective grid size
   logic [GWW-1:0] gw_eff;
   logic [GHW-1:0] gh_eff;
   logic [XW-1:0]  gw_m1;
   logic [YW-1:0]  gh_m1;

   always_comb begin
      if (cfg.grid_width < bcim_pkg::SIZE_W'(bcim_pkg::MIN_GRID_SIZE)) begin
         gw_eff = GWW'(bcim_pkg::MIN_GRID_SIZE);
      end else if (32'(cfg.grid_width) > 32'(MAX_GRID_WIDTH)) begin
         gw_eff = GWW'(MAX_GRID_WIDTH);
      end else begin
         gw_eff = GWW'(cfg.grid_width);
      end
      if (cfg.grid_height < bcim_pkg::SIZE_W'(bcim_pkg::MIN_GRID_SIZE)) begin
         gh_eff = GHW'(bcim_pkg::MIN_GRID_SIZE);
      end else if (32'(cfg.grid_height) > 32'(MAX_GRID_HEIGHT)) begin
         gh_eff = GHW'(MAX_GRID_HEIGHT);
      end else begin
         gh_eff = GHW'(cfg.grid_height);
      end
      gw_m1 = XW'(gw_eff - GWW'(1));
      gh_m1 = YW'(gh_eff - GHW'(1));
   end

   // stage A: offset from origin
   logic                  a_vld_ff, a_vld_in;
   logic signed [D_W-1:0] dx_ff, dx_in, dy_ff, dy_in;

   always_comb begin
      a_vld_in = start;
      dx_in    = D_W'(pos_x) - D_W'(cfg.origin_x);
      dy_in    = D_W'(pos_y) - D_W'(cfg.origin_y);
   end

   // stage B: scale multiply, zero when the offset is not positive
   logic             b_vld_ff, b_vld_in;
   logic [P_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic [31:0]      mx, my;

   always_comb begin
      b_vld_in = a_vld_ff;
      mx       = (dx_ff > D_W'(0)) ? dx_ff[31:0] : '0;
      my       = (dy_ff > D_W'(0)) ? dy_ff[31:0] : '0;
      px_in    = P_W'(mx) * P_W'(cfg.scale_x);
      py_in    = P_W'(my) * P_W'(cfg.scale_y);
   end

   // stage C: drop scale fraction, clip to the far edge
   logic            c_vld_ff, c_vld_in;
   logic [CX_W-1:0] gx_ff, gx_in;
   logic [CY_W-1:0] gy_ff, gy_in;
   logic [G_W-1:0]  gx_raw, gy_raw, gx_max, gy_max;

   always_comb begin
      c_vld_in = b_vld_ff;
      gx_raw   = px_ff[P_W-1:SHIFT];
      gy_raw   = py_ff[P_W-1:SHIFT];
      gx_max   = G_W'(gw_m1) << FRAC_BITS;
      gy_max   = G_W'(gh_m1) << FRAC_BITS;
      gx_in    = (gx_raw > gx_max) ? CX_W'(gx_max) : CX_W'(gx_raw);
      gy_in    = (gy_raw > gy_max) ? CY_W'(gy_max) : CY_W'(gy_raw);
   end

   // stage D: corner cells, row bases, fractions
   logic              d_vld_ff, d_vld_in;
   logic [XW-1:0]     x1_ff, x1_in, x2_ff, x2_in;
   logic [YW-1:0]     y1_ff, y1_in, y2_ff, y2_in;
   logic [ADDR_W-1:0] base1_ff, base1_in, base2_ff, base2_in;
   logic [FRAC_BITS-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [BX_W-1:0]   row1, row2;

   always_comb begin
      d_vld_in = c_vld_ff;
      x1_in    = gx_ff[CX_W-1:FRAC_BITS];
      y1_in    = gy_ff[CY_W-1:FRAC_BITS];
      x2_in    = x1_in + XW'(x1_in < gw_m1);
      y2_in    = y1_in + YW'(y1_in < gh_m1);
      fx_in    = gx_ff[FRAC_BITS-1:0];
      fy_in    = gy_ff[FRAC_BITS-1:0];
      row1     = BX_W'(y1_in) * BX_W'(gw_eff);
      row2     = BX_W'(y2_in) * BX_W'(gw_eff);
      base1_in = ADDR_W'(row1);
      base2_in = ADDR_W'(row2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
      end
      if (a_vld_in) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (b_vld_in) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (c_vld_in) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (d_vld_in) begin
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         y1_ff    <= y1_in;
         y2_ff    <= y2_in;
         base1_ff <= base1_in;
         base2_ff <= base2_in;
         fx_ff    <= fx_in;
         fy_ff    <= fy_in;
      end
   end

   assign done   = d_vld_ff;
   assign x1     = x1_ff;
   assign x2     = x2_ff;
   assign y1     = y1_ff;
   assign y2     = y2_ff;
   assign base1  = base1_ff;
   assign base2  = base2_ff;
   assign frac_x = fx_ff;
   assign frac_y = fy_ff;

endmodule

// ===== rtl/bcim_slot.sv =====
// Cell-to-slot map: clearing sweep, read-modify-write with forwarding, slot counter.
module bcim_slot #(
   parameter int MAX_GRID_WIDTH  = bcim_pkg::MAX_GRID_WIDTH_DEFAULT,
   parameter int MAX_GRID_HEIGHT = bcim_pkg::MAX_GRID_HEIGHT_DEFAULT,
   localparam int DEPTH  = MAX_GRID_WIDTH * MAX_GRID_HEIGHT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bcim_pkg::corner_req_type req,
   input  logic [ADDR_W-1:0]        req_addr,
   output bcim_pkg::corner_rsp_type rsp,
   output logic                     clearing
);

   localparam int EW = bcim_pkg::ENTRY_W;

   // clearing sweep after reset
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // lookup stage
   bcim_pkg::corner_req_type p_ff, p_in;
   logic [ADDR_W-1:0]        p_addr_ff;
   logic [EW-1:0]            rd_data;

   assign p_in = req;

   // last looked-up entry, for back-to-back hits on the same cell
   logic              last_vld_ff, last_vld_in;
   logic [ADDR_W-1:0] last_addr_ff;
   logic [EW-1:0]     last_val_ff, last_val_in;
   logic [EW-1:0]     used_ff, used_in;
   logic [EW-1:0]     cur, new_cnt;
   logic              is_new;

   bcim_pkg::corner_rsp_type rsp_ff, rsp_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [EW-1:0]     wr_data;

   always_comb begin
      cur         = (last_vld_ff && last_addr_ff == p_addr_ff) ? last_val_ff : rd_data;
      is_new      = (cur == '0);
      new_cnt     = used_ff + EW'(1);
      last_val_in = is_new ? new_cnt : cur;
      last_vld_in = last_vld_ff | p_ff.vld;
      used_in     = (p_ff.vld && is_new) ? new_cnt : used_ff;

      rsp_in.vld    = p_ff.vld;
      rsp_in.corner = p_ff.corner;
      rsp_in.cell_x = p_ff.cell_x;
      rsp_in.cell_y = p_ff.cell_y;
      rsp_in.slot   = bcim_pkg::SLOT_W'(last_val_in - EW'(1));
      rsp_in.weight = p_ff.weight;
      rsp_in.is_new = is_new;
      rsp_in.last   = p_ff.last;

      if (clr_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = p_ff.vld && is_new;
         wr_addr = p_addr_ff;
         wr_data = new_cnt;
      end
   end

   bcim_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         p_ff.vld    <= 1'b0;
         last_vld_ff <= 1'b0;
         used_ff     <= '0;
         rsp_ff.vld  <= 1'b0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
         p_ff.vld    <= p_in.vld;
         last_vld_ff <= last_vld_in;
         used_ff     <= used_in;
         rsp_ff.vld  <= rsp_in.vld;
      end
      p_ff.corner   <= p_in.corner;
      p_ff.cell_x   <= p_in.cell_x;
      p_ff.cell_y   <= p_in.cell_y;
      p_ff.weight   <= p_in.weight;
      p_ff.last     <= p_in.last;
      p_addr_ff     <= req_addr;
      rsp_ff.corner <= rsp_in.corner;
      rsp_ff.cell_x <= rsp_in.cell_x;
      rsp_ff.cell_y <= rsp_in.cell_y;
      rsp_ff.slot   <= rsp_in.slot;
      rsp_ff.weight <= rsp_in.weight;
      rsp_ff.is_new <= rsp_in.is_new;
      rsp_ff.last   <= rsp_in.last;
      if (p_ff.vld) begin
         last_addr_ff <= p_addr_ff;
         last_val_ff  <= last_val_in;
      end
   end

   assign rsp      = rsp_ff;
   assign clearing = clr_ff;

endmodule

// ===== rtl/bcim_checker.sv =====
// Port-level checker for the bilinear corner index mapper, bound to the top level.
module bcim_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  rsp_valid,
   input logic [bcim_pkg::CORNER_W-1:0]         rsp_corner,
   input logic                                  rsp_last
);

   // corner words come back to back until the last one
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("corner burst broken");

   a_corner_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_corner == $past(rsp_corner) + 2'd1)
      else $error("corner order wrong");

   a_first_corner: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_corner == bcim_pkg::CORNER_X1Y1)
      else $error("burst does not start at x1y1");

   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("word after last corner");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

endmodule

bind bilinear_corner_index_mapper_unit bcim_checker u_bcim_checker (.*);
